FILE: rtl/token_bucket_table_defines.svh
// assertion macros for the token bucket table
`ifndef TOKEN_BUCKET_TABLE_DEFINES_SVH
`define TOKEN_BUCKET_TABLE_DEFINES_SVH

// condition holds in the same cycle
`define TBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the next cycle
`define TBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tbt_pkg.sv
package tbt_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_OPEN   = 3'd1,
    OP_FETCH  = 3'd2,
    OP_RETURN = 3'd3,
    OP_CLOSE  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_AMOUNT = 3'd1,
    ST_NO_SLOT    = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_NOT_OPEN   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_TICK,
    S_TICK_END,
    S_EXEC,
    S_READ,
    S_UPDATE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] rate;
    logic [15:0] cap;
    logic [15:0] tokens;
  } bucket_t;

  typedef struct packed {
    logic capture;
    logic tick_rd;
    logic mem_rd;
    logic exec;
    logic update;
    logic load_out;
  } tbt_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       go_mem;
    logic       cnt_last;
    logic       out_free;
  } tbt_sts_t;

  localparam int IN_W  = 56;
  localparam int OUT_W = 24;

  function automatic logic [15:0] capped_add(input logic [15:0] tok,
                                             input logic [15:0] add,
                                             input logic [15:0] cap);
    logic [16:0] sum;
    sum = {1'b0, tok} + {1'b0, add};
    return (sum > {1'b0, cap}) ? cap : sum[15:0];
  endfunction

endpackage

FILE: rtl/tbt_ctrl.sv
`include "token_bucket_table_defines.svh"

module tbt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  tbt_pkg::tbt_sts_t sts,
  output tbt_pkg::tbt_cmd_t cmd
);

  tbt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tbt_pkg::S_IDLE: begin
        if (s_tvalid) state_next = tbt_pkg::S_DISPATCH;
      end
      tbt_pkg::S_DISPATCH: begin
        if (sts.op == tbt_pkg::OP_TICK) state_next = tbt_pkg::S_TICK;
        else if (sts.go_mem) state_next = tbt_pkg::S_READ;
        else state_next = tbt_pkg::S_EXEC;
      end
      tbt_pkg::S_TICK: begin
        if (sts.cnt_last) state_next = tbt_pkg::S_TICK_END;
      end
      tbt_pkg::S_TICK_END: state_next = tbt_pkg::S_DONE;
      tbt_pkg::S_EXEC:     state_next = tbt_pkg::S_DONE;
      tbt_pkg::S_READ:     state_next = tbt_pkg::S_UPDATE;
      tbt_pkg::S_UPDATE:   state_next = tbt_pkg::S_DONE;
      tbt_pkg::S_DONE: begin
        if (sts.out_free) state_next = tbt_pkg::S_IDLE;
      end
      default: state_next = tbt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      tbt_pkg::S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      tbt_pkg::S_TICK:     cmd.tick_rd = 1'b1;
      tbt_pkg::S_TICK_END: cmd.exec = 1'b1;
      tbt_pkg::S_EXEC:     cmd.exec = 1'b1;
      tbt_pkg::S_READ:     cmd.mem_rd = 1'b1;
      tbt_pkg::S_UPDATE:   cmd.update = 1'b1;
      tbt_pkg::S_DONE:     cmd.load_out = sts.out_free;
      default: cmd = '0;
    endcase
  end

  `TBT_ASSERT_NEXT(a_accept_dispatch, s_tvalid && s_tready, state == tbt_pkg::S_DISPATCH, "accepted word not dispatched")
  `TBT_ASSERT_NEXT(a_tick_sweep, state == tbt_pkg::S_TICK && !sts.cnt_last, state == tbt_pkg::S_TICK, "tick sweep ended early")
  `TBT_ASSERT_NEXT(a_read_update, state == tbt_pkg::S_READ, state == tbt_pkg::S_UPDATE, "read not followed by update")
  `TBT_ASSERT_NEXT(a_done_hold, state == tbt_pkg::S_DONE && !sts.out_free, state == tbt_pkg::S_DONE, "result dropped while output busy")
  `TBT_ASSERT_NOW(a_one_mem_op, cmd.tick_rd || cmd.mem_rd, !cmd.exec && !cmd.update && !cmd.load_out, "memory read overlaps result step")

endmodule

FILE: rtl/tbt_datapath.sv
module tbt_datapath #(
  parameter int NUM_BUCKETS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tbt_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [tbt_pkg::OUT_W-1:0] m_tdata,
  input  tbt_pkg::tbt_cmd_t         cmd,
  output tbt_pkg::tbt_sts_t         sts
);

  localparam int IDX_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int OPEN_LIM = (NUM_BUCKETS < 16) ? NUM_BUCKETS : 16;

  logic [2:0]  op;
  logic [3:0]  slot;
  logic [15:0] amount;
  logic [15:0] rate;
  logic [15:0] burst_limit;

  logic [NUM_BUCKETS-1:0] slot_open;
  tbt_pkg::bucket_t       mem [NUM_BUCKETS];
  tbt_pkg::bucket_t       rd_q;
  logic [IDX_W-1:0]       cnt;
  logic                   pipe_vld;
  logic [IDX_W-1:0]       pipe_idx;

  logic [2:0]  res_status;
  logic [15:0] res_granted;
  logic [3:0]  res_opened;

  logic [IDX_W-1:0] slot_idx;
  logic             slot_usable;
  logic             found;
  logic [3:0]       free_idx;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  tbt_pkg::bucket_t wr_data;
  logic [IDX_W-1:0] rd_addr;

  logic [2:0]  exec_status;
  logic [3:0]  exec_opened;
  logic [2:0]  upd_status;
  logic [15:0] upd_granted;
  logic [15:0] upd_tokens;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op          <= s_tdata[2:0];
      slot        <= s_tdata[6:3];
      amount      <= s_tdata[22:7];
      rate        <= s_tdata[38:23];
      burst_limit <= s_tdata[54:39];
    end
  end

  assign slot_idx    = IDX_W'(slot);
  assign slot_usable = (32'(slot) < NUM_BUCKETS) && slot_open[slot_idx];

  // lowest free slot among those the slot field can address
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = OPEN_LIM - 1; i >= 0; i--) begin
      if (!slot_open[i]) begin
        found    = 1'b1;
        free_idx = 4'(i);
      end
    end
  end

  assign sts.op       = op;
  assign sts.go_mem   = (op == tbt_pkg::OP_FETCH || op == tbt_pkg::OP_RETURN) &&
                        (amount != 16'd0) && slot_usable;
  assign sts.cnt_last = (cnt == IDX_W'(NUM_BUCKETS - 1));
  assign sts.out_free = !m_tvalid || m_tready;

  // tick sweep counter and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= 1'b0;
    end else begin
      pipe_vld <= cmd.tick_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cnt <= '0;
    end else if (cmd.tick_rd) begin
      cnt <= cnt + 1'b1;
    end
    if (cmd.tick_rd) begin
      pipe_idx <= cnt;
    end
  end

  assign rd_addr = cmd.tick_rd ? cnt : slot_idx;

  always_ff @(posedge clk) begin
    if (cmd.tick_rd || cmd.mem_rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    upd_status  = tbt_pkg::ST_OK;
    upd_granted = amount;
    upd_tokens  = tbt_pkg::capped_add(rd_q.tokens, amount, rd_q.cap);
    if (op == tbt_pkg::OP_FETCH) begin
      if (rd_q.tokens == 16'd0) begin
        upd_status  = tbt_pkg::ST_EMPTY;
        upd_granted = '0;
      end else begin
        upd_granted = (rd_q.tokens < amount) ? rd_q.tokens : amount;
      end
      upd_tokens = rd_q.tokens - upd_granted;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_idx;
    wr_data = rd_q;
    if (pipe_vld) begin
      wr_en          = slot_open[pipe_idx];
      wr_addr        = pipe_idx;
      wr_data.tokens = tbt_pkg::capped_add(rd_q.tokens, rd_q.rate, rd_q.cap);
    end else if (cmd.exec && op == tbt_pkg::OP_OPEN) begin
      wr_en   = found;
      wr_addr = IDX_W'(free_idx);
      wr_data = '{rate: rate, cap: burst_limit, tokens: 16'd0};
    end else if (cmd.update) begin
      wr_en          = 1'b1;
      wr_data.tokens = upd_tokens;
    end
  end

  always_comb begin
    exec_status = tbt_pkg::ST_OK;
    exec_opened = '0;
    case (op)
      tbt_pkg::OP_OPEN: begin
        if (found) exec_opened = free_idx;
        else exec_status = tbt_pkg::ST_NO_SLOT;
      end
      tbt_pkg::OP_FETCH, tbt_pkg::OP_RETURN: begin
        if (amount == 16'd0) exec_status = tbt_pkg::ST_BAD_AMOUNT;
        else if (!slot_usable) exec_status = tbt_pkg::ST_NOT_OPEN;
      end
      tbt_pkg::OP_CLOSE: begin
        if (!slot_usable) exec_status = tbt_pkg::ST_NOT_OPEN;
      end
      default: exec_status = tbt_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_open <= '0;
    end else if (cmd.exec) begin
      if (op == tbt_pkg::OP_OPEN && found) begin
        slot_open[IDX_W'(free_idx)] <= 1'b1;
      end else if (op == tbt_pkg::OP_CLOSE && slot_usable) begin
        slot_open[slot_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status  <= exec_status;
      res_granted <= '0;
      res_opened  <= exec_opened;
    end else if (cmd.update) begin
      res_status  <= upd_status;
      res_granted <= upd_granted;
      res_opened  <= '0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {1'b0, res_opened, res_granted, res_status};
    end
  end

endmodule

FILE: rtl/token_bucket_table.sv
// channel  dir  fields
// s_*      in   opcode, slot, amount, rate, burst_limit
// m_*      out  status, granted, opened_slot
//
// one word in flight; next word taken while the result waits in the output register
// tick: one bucket read per cycle through the memory port
// open, close and rejected words: dispatch, exec, done; fetch and return: dispatch, read, update, done
// rst clears slot state, the controller and the output valid
// a stalled m_tready holds the result and blocks the following word at its last step
module token_bucket_table #(
  parameter int NUM_BUCKETS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // opcode, slot, amount, rate, burst_limit, pad
  input  logic [tbt_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status, granted, opened_slot, pad
  output logic [tbt_pkg::OUT_W-1:0] m_tdata
);

  tbt_pkg::tbt_cmd_t cmd;
  tbt_pkg::tbt_sts_t sts;

  tbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tbt_datapath #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

FILE: bench/tb_token_bucket_table.sv
module tb_token_bucket_table;
  import tbt_pkg::*;

  localparam int NUM_BUCKETS = 16;
  localparam int RANDOM_WORDS = 500;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST = 3'd7;

  typedef struct {
    status_t     status;
    logic [15:0] granted;
    logic [3:0]  opened_slot;
  } bucket_reply_t;

  class bucket_ledger;
    localparam int SLOTS = 16;
    bit            live[SLOTS];
    logic [15:0]   rate[SLOTS];
    logic [15:0]   cap[SLOTS];
    logic [15:0]   tokens[SLOTS];
    bucket_reply_t replies_due[$];
    int            mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        live[i] = 1'b0;
        rate[i] = '0;
        cap[i] = '0;
        tokens[i] = '0;
      end
      mismatches = 0;
    endfunction

    function logic [15:0] fill_to_cap(logic [15:0] held, logic [15:0] add, logic [15:0] limit);
      logic [16:0] total;
      total = {1'b0, held} + {1'b0, add};
      if (total > {1'b0, limit}) return limit;
      return total[15:0];
    endfunction

    function int live_count();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) n += live[i];
      return n;
    endfunction

    function logic [3:0] pick_slot();
      int choices[$];
      for (int i = 0; i < SLOTS; i++) if (live[i]) choices.push_back(i);
      if (choices.size() == 0 || $urandom_range(0, 7) == 0) return 4'($urandom_range(0, SLOTS - 1));
      return 4'(choices[$urandom_range(0, choices.size() - 1)]);
    endfunction

    function void note_command(logic [2:0] op, logic [3:0] slot, logic [15:0] amt,
                               logic [15:0] rt, logic [15:0] bl);
      bucket_reply_t r;
      r.status = ST_OK;
      r.granted = '0;
      r.opened_slot = '0;
      case (op)
        OP_TICK: begin
          for (int i = 0; i < SLOTS; i++)
            if (live[i]) tokens[i] = fill_to_cap(tokens[i], rate[i], cap[i]);
        end
        OP_OPEN: begin
          r.status = ST_NO_SLOT;
          for (int i = 0; i < SLOTS; i++) begin
            if (!live[i]) begin
              live[i] = 1'b1;
              rate[i] = rt;
              cap[i] = bl;
              tokens[i] = '0;
              r.opened_slot = 4'(i);
              r.status = ST_OK;
              break;
            end
          end
        end
        OP_FETCH, OP_RETURN: begin
          if (amt == '0) begin
            r.status = ST_BAD_AMOUNT;
          end else if (!live[slot]) begin
            r.status = ST_NOT_OPEN;
          end else if (op == OP_FETCH) begin
            if (tokens[slot] == '0) begin
              r.status = ST_EMPTY;
            end else begin
              r.granted = (tokens[slot] < amt) ? tokens[slot] : amt;
              tokens[slot] = tokens[slot] - r.granted;
            end
          end else begin
            tokens[slot] = fill_to_cap(tokens[slot], amt, cap[slot]);
            r.granted = amt;
          end
        end
        OP_CLOSE: begin
          if (!live[slot]) r.status = ST_NOT_OPEN;
          else live[slot] = 1'b0;
        end
        default: ;
      endcase
      replies_due.push_back(r);
    endfunction

    task report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_reply(input logic [OUT_W-1:0] word);
      bucket_reply_t want;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("word %h with nothing pending", word));
        return;
      end
      want = replies_due.pop_front();
      if (word[2:0] !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", word[2:0], want.status));
      if (word[18:3] !== want.granted)
        report_mismatch($sformatf("granted %0d, want %0d", word[18:3], want.granted));
      if (word[22:19] !== want.opened_slot)
        report_mismatch($sformatf("opened_slot %0d, want %0d", word[22:19], want.opened_slot));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  bucket_ledger ledger = new();
  int words_sent = 0;
  int burst_left = 0;
  int stall_left = 0;
  int cycle_count = 0;

  token_bucket_table #(.NUM_BUCKETS(NUM_BUCKETS)) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: runs of stalls, with calm stretches where tready stays high
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) ledger.check_reply(m_tdata);
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!cycle_count[9] && $urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 24);
    end
  end

  function automatic logic [15:0] pick_amount();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'hFFFF;
      2, 3, 4, 5: return 16'($urandom_range(1, 40));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic push_word(input logic [2:0] op, input logic [3:0] slot,
                           input logic [15:0] amt, input logic [15:0] rt,
                           input logic [15:0] bl);
    s_tdata <= {1'b0, bl, rt, amt, slot, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    ledger.note_command(op, slot, amt, rt, bl);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  task automatic push_open();
    logic [15:0] rt;
    logic [15:0] bl;
    if ($urandom_range(0, 3) != 0) begin
      rt = 16'($urandom_range(0, 30));
      bl = 16'($urandom_range(0, 200));
    end else begin
      rt = 16'($urandom_range(0, 16'hFFFF));
      bl = 16'($urandom_range(0, 16'hFFFF));
    end
    push_word(OP_OPEN, 4'($urandom_range(0, 15)), pick_amount(), rt, bl);
  endtask

  task automatic push_random();
    push_word(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
              16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
              16'($urandom_range(0, 16'hFFFF)));
  endtask

  task automatic push_traffic();
    case ($urandom_range(0, 19))
      0, 1, 2, 3: push_word(OP_TICK, ledger.pick_slot(), pick_amount(), '0, '0);
      4, 5, 6, 7, 8, 9, 10: push_word(OP_FETCH, ledger.pick_slot(), pick_amount(), '0, '0);
      11, 12, 13, 14, 15: push_word(OP_RETURN, ledger.pick_slot(), pick_amount(), '0, '0);
      16: push_word(OP_CLOSE, ledger.pick_slot(), pick_amount(), '0, '0);
      17, 18: push_open();
      default: push_random();
    endcase
  endtask

  initial begin
    int target;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed
    push_word(OP_CLOSE, 4'd15, 16'd1, '0, '0);
    push_word(OP_FETCH, 4'd0, '0, '0, '0);
    push_word(OP_RETURN, 4'd0, 16'd5, '0, '0);
    push_word(OP_OPEN, 4'd9, '0, 16'hFFFF, 16'hFFFF);
    push_word(OP_OPEN, 4'd0, '0, '0, '0);
    push_word(OP_FETCH, 4'd0, 16'd1, '0, '0);
    push_word(OP_TICK, '0, '0, '0, '0);
    push_word(OP_TICK, '0, '0, '0, '0);
    push_word(OP_FETCH, 4'd0, 16'hFFFF, '0, '0);
    push_word(OP_RETURN, 4'd0, 16'hFFFF, '0, '0);
    push_word(OP_RETURN, 4'd0, 16'd1, '0, '0);
    push_word(OP_FETCH, 4'd0, 16'd7, '0, '0);
    push_word(OP_FETCH, 4'd1, 16'd7, '0, '0);
    push_word(OP_RETURN, 4'd1, 16'd3, '0, '0);
    push_word(OP_CLOSE, 4'd1, '0, '0, '0);
    push_word(OP_CLOSE, 4'd1, '0, '0, '0);
    push_word(OP_OPEN, 4'hF, 16'hFFFF, 16'd2, 16'd3);
    push_word(OP_FETCH, 4'd2, 16'd1, '0, '0);
    for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
      push_word(3'(k), 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // random episodes
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          while (ledger.live_count() < NUM_BUCKETS) push_open();
          push_open();
        end
        2: repeat ($urandom_range(1, 6))
          push_word(OP_CLOSE, ledger.pick_slot(), pick_amount(), '0, '0);
        8, 9: repeat ($urandom_range(1, 4)) push_random();
        default: repeat ($urandom_range(5, 20)) push_traffic();
      endcase
    end
    s_tvalid <= 1'b0;

    while (ledger.replies_due.size() != 0) @(posedge clk);
    repeat (NUM_BUCKETS + 20) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
